[hdl/w16_pkg.sv]
// ----------------------------------------------------------------------------
// w16_pkg
// Shared types and codes for the stepped 16-bit processor.
// ----------------------------------------------------------------------------
`default_nettype none
package w16_pkg;

  typedef enum logic [1:0] {
    ACT_STEP  = 2'd0,
    ACT_MEM   = 2'd1,
    ACT_REG   = 2'd2,
    ACT_REPLY = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SERVICE  = 3'd1,
    ST_HALTED   = 3'd2,
    ST_DIV_ZERO = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_REFUSED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_HALT = 2'd2
  } mode_t;

  typedef enum logic [4:0] {
    OP_MOV, OP_ADD, OP_LOAD, OP_STORE, OP_SUB, OP_AND, OP_OR, OP_XOR,
    OP_ASR, OP_LSR, OP_LSL, OP_MUL, OP_DIV_S, OP_DIV_U, OP_REM_S, OP_REM_U,
    OP_LT_S, OP_LT_U, OP_GT_S, OP_GT_U, OP_GE_S, OP_GE_U, OP_LE_S, OP_LE_U,
    OP_EQ, OP_NE, OP_NOT, OP_NEG, OP_JAL, OP_FRAME, OP_LOAD_FB, OP_STORE_FB
  } alu_op_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_FETCH, S_DECODE, S_MEMRD, S_DIV, S_FINISH
  } state_t;

  localparam logic [12:0] SVC_HALT   = 13'd0;
  localparam logic [12:0] SVC_PUTC   = 13'd1;
  localparam logic [12:0] SVC_DEBUG  = 13'd3;
  localparam logic [12:0] SVC_LAST   = 13'd8;
  localparam logic [3:0]  IMM_NOT_R0 = 4'hf;
  localparam logic [3:0]  REG_PC     = 4'd15;
  localparam logic [3:0]  REG_FB     = 4'd14;
  localparam logic [3:0]  REG_ARG1   = 4'd1;
  localparam logic [3:0]  REG_ARG2   = 4'd2;
  localparam logic [3:0]  REG_LIT    = 4'd0;

  typedef struct packed {
    logic clear;
    logic accept;
    logic start;
    logic fetch;
    logic decode;
    logic memrd;
    logic div_wait;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic start_fetch;
    logic dec_memrd;
    logic dec_div;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

[hdl/word16_cpu_execute_step_unit.sv]
// sequence: a step word runs start, fetch, decode and finish, with a memory read for a load or a divider wait;
// memory write, register write, reply and refused step words run start and finish only
// throughput: one word at a time, next word taken once its result has left the output register
// single-port main memory sets the fetch and data access sequence
// reset: synchronous; after reset every word of the memory is cleared
// before the first word is taken, registers and zero-test word reset to zero
`default_nettype none
module word16_cpu_execute_step_unit #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] address,
  input  wire logic [3:0]  reg_index,
  input  wire logic [15:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [15:0]      program_counter,
  output logic [3:0]       service_number,
  output logic             needs_reply,
  output logic [15:0]      arg_first,
  output logic [15:0]      arg_second
);
  import w16_pkg::*;

  cmd_t cmd;
  sts_t sts;

  w16_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  w16_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .action          (action),
    .address         (address),
    .reg_index       (reg_index),
    .value           (value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .program_counter (program_counter),
    .service_number  (service_number),
    .needs_reply     (needs_reply),
    .arg_first       (arg_first),
    .arg_second      (arg_second)
  );
endmodule
`default_nettype wire

[hdl/w16_ram.sv]
// ----------------------------------------------------------------------------
// w16_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module w16_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hdl/w16_div.sv]
// ----------------------------------------------------------------------------
// w16_div
// Radix-2 restoring divider, signed or unsigned.
// ----------------------------------------------------------------------------
`default_nettype none
module w16_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        sgn,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      quo,
  output logic [15:0]      rem
);
  logic [4:0]  cnt;
  logic        busy;
  logic [15:0] rem_r, quo_r, dvs;
  logic        neg_q, neg_r;
  logic [16:0] shifted, diff;
  logic [15:0] ua, ub;

  assign ua      = (sgn && dividend[15]) ? 16'(-dividend) : dividend;
  assign ub      = (sgn && divisor[15]) ? 16'(-divisor) : divisor;
  assign shifted = {rem_r, quo_r[15]};
  assign diff    = shifted - {1'b0, dvs};
  assign quo     = neg_q ? 16'(-quo_r) : quo_r;
  assign rem     = neg_r ? 16'(-rem_r) : rem_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 5'd1);
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 5'd16;
        rem_r <= '0;
        quo_r <= ua;
        dvs   <= ub;
        neg_q <= sgn && (dividend[15] ^ divisor[15]);
        neg_r <= sgn && dividend[15];
      end else if (busy) begin
        // one quotient bit per cycle
        if (!diff[16]) begin
          rem_r <= diff[15:0];
          quo_r <= {quo_r[14:0], 1'b1};
        end else begin
          rem_r <= shifted[15:0];
          quo_r <= {quo_r[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

[hdl/w16_ctrl.sv]
// ----------------------------------------------------------------------------
// w16_ctrl
// Sequencer: memory clear; per word start, step fetch/decode/wait, finish.
// ----------------------------------------------------------------------------
`default_nettype none
module w16_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire w16_pkg::sts_t sts,
  output w16_pkg::cmd_t      cmd
);
  import w16_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = !(state == S_IDLE && !sts.out_busy);
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = sts.start_fetch ? S_FETCH : S_FINISH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.dec_memrd)    state_next = S_MEMRD;
        else if (sts.dec_div) state_next = S_DIV;
        else                  state_next = S_FINISH;
      end
      S_MEMRD: begin
        cmd.memrd  = 1'b1;
        state_next = S_FINISH;
      end
      S_DIV: begin
        cmd.div_wait = 1'b1;
        if (sts.div_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_START) else $error("accept did not start");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> state == S_DIV) else $error("divider done outside wait");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_busy) else $error("result register still busy");
endmodule
`default_nettype wire

[hdl/w16_dp.sv]
// ----------------------------------------------------------------------------
// w16_dp
// Datapath: register file, main memory, alu, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module w16_dp #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire w16_pkg::cmd_t cmd,
  output w16_pkg::sts_t      sts,
  input  wire logic [1:0]    action,
  input  wire logic [15:0]   address,
  input  wire logic [3:0]    reg_index,
  input  wire logic [15:0]   value,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         status,
  output logic [15:0]        program_counter,
  output logic [3:0]         service_number,
  output logic               needs_reply,
  output logic [15:0]        arg_first,
  output logic [15:0]        arg_second
);
  import w16_pkg::*;

  logic [15:0] rf [16];
  action_t     act_q;
  logic [15:0] addr_q, val_q;
  logic [3:0]  ri_q;
  logic [15:0] ir, ztw;
  mode_t       mode;
  status_t     st_code;
  logic [3:0]  svc_q;
  logic        rep_q;
  logic [ADDR_BITS-1:0] clr_cnt;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [15:0]          ram_wd, ram_rd;

  logic        is_lit, is_alu, is_svc;
  alu_op_t     op;
  logic [3:0]  d;
  logic [15:0] a, b, fb, maddr, alu_r, br_off;
  logic        is_div, b_zero, take;
  logic [12:0] svc_n;
  logic        div_done;
  logic [15:0] div_quo, div_rem;
  logic        div_sgn;

  assign is_lit = !ir[15];
  assign is_alu = ir[15:14] == 2'b10;
  assign is_svc = ir[15:13] == 3'b110;
  assign op     = alu_op_t'(ir[12:8]);
  assign d      = ir[7:4];
  assign a      = rf[d];
  assign b      = ir[13] ? ((ir[3:0] == IMM_NOT_R0) ? ~rf[REG_LIT] : {12'd0, ir[3:0]})
                         : rf[ir[3:0]];
  assign fb     = rf[REG_FB] + b;
  assign maddr  = (op == OP_LOAD || op == OP_STORE) ? b : fb;
  assign is_div = is_alu && (op == OP_DIV_S || op == OP_DIV_U ||
                             op == OP_REM_S || op == OP_REM_U);
  assign b_zero = b == 16'd0;
  assign div_sgn = op == OP_DIV_S || op == OP_REM_S;
  assign svc_n  = ir[12:0];
  assign br_off = {{4{ir[11]}}, ir[11:0]};
  assign take   = ir[12] ? (ztw != 16'd0) : (ztw == 16'd0);

  always_comb begin
    case (op)
      OP_MOV:   alu_r = b;
      OP_ADD:   alu_r = a + b;
      OP_SUB:   alu_r = a - b;
      OP_AND:   alu_r = a & b;
      OP_OR:    alu_r = a | b;
      OP_XOR:   alu_r = a ^ b;
      OP_ASR:   alu_r = (b[15:4] != 12'd0) ? {16{a[15]}} : 16'($signed(a) >>> b[3:0]);
      OP_LSR:   alu_r = (b[15:4] != 12'd0) ? 16'd0 : a >> b[3:0];
      OP_LSL:   alu_r = (b[15:4] != 12'd0) ? 16'd0 : a << b[3:0];
      OP_MUL:   alu_r = 16'(a * b);
      OP_LT_S:  alu_r = {15'd0, $signed(a) < $signed(b)};
      OP_LT_U:  alu_r = {15'd0, a < b};
      OP_GT_S:  alu_r = {15'd0, $signed(a) > $signed(b)};
      OP_GT_U:  alu_r = {15'd0, a > b};
      OP_GE_S:  alu_r = {15'd0, $signed(a) >= $signed(b)};
      OP_GE_U:  alu_r = {15'd0, a >= b};
      OP_LE_S:  alu_r = {15'd0, $signed(a) <= $signed(b)};
      OP_LE_U:  alu_r = {15'd0, a <= b};
      OP_EQ:    alu_r = {15'd0, a == b};
      OP_NE:    alu_r = {15'd0, a != b};
      OP_NOT:   alu_r = ~b;
      OP_NEG:   alu_r = 16'(16'd0 - b);
      OP_FRAME: alu_r = fb;
      default:  alu_r = a;
    endcase
  end

  always_comb begin
    ram_addr = clr_cnt;
    ram_we   = 1'b0;
    ram_wd   = '0;
    if (cmd.clear) begin
      ram_we = 1'b1;
    end else if (cmd.start) begin
      if (act_q == ACT_MEM) begin
        ram_addr = addr_q[ADDR_BITS-1:0];
        ram_we   = 1'b1;
        ram_wd   = val_q;
      end else begin
        ram_addr = rf[REG_PC][ADDR_BITS-1:0];
      end
    end else if (cmd.decode) begin
      ram_addr = maddr[ADDR_BITS-1:0];
      ram_we   = is_alu && (op == OP_STORE || op == OP_STORE_FB);
      ram_wd   = a;
    end
  end

  w16_ram #(.WIDTH(16), .DEPTH(1 << ADDR_BITS)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_rd)
  );

  w16_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.decode && sts.dec_div),
    .sgn      (div_sgn),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign sts.clear_last  = clr_cnt == {ADDR_BITS{1'b1}};
  assign sts.start_fetch = act_q == ACT_STEP && mode == MODE_RUN;
  assign sts.dec_memrd   = is_alu && (op == OP_LOAD || op == OP_LOAD_FB);
  assign sts.dec_div     = is_div && !b_zero;
  assign sts.div_done    = div_done;
  assign sts.out_busy    = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q  <= action_t'(action);
      addr_q <= address;
      ri_q   <= reg_index;
      val_q  <= value;
    end
    if (cmd.fetch) ir <= ram_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) rf[i] <= '0;
      ztw       <= '0;
      mode      <= MODE_RUN;
      out_valid <= 1'b0;
      clr_cnt   <= '0;
      st_code   <= ST_OK;
      svc_q     <= '0;
      rep_q     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.start) begin
        svc_q   <= '0;
        rep_q   <= 1'b0;
        case (act_q)
          ACT_STEP: st_code <= (mode != MODE_RUN) ? ST_REFUSED : ST_OK;
          ACT_REG: begin
            st_code  <= ST_OK;
            rf[ri_q] <= val_q;
          end
          ACT_REPLY: begin
            if (mode != MODE_WAIT) begin
              st_code <= ST_REFUSED;
            end else begin
              st_code      <= ST_OK;
              rf[REG_ARG1] <= val_q;
              ztw          <= val_q;
              mode         <= MODE_RUN;
            end
          end
          default: st_code <= ST_OK;
        endcase
      end
      if (cmd.fetch) rf[REG_PC] <= rf[REG_PC] + 16'd1;
      if (cmd.decode) begin
        if (is_lit) begin
          rf[REG_LIT] <= ir;
        end else if (is_alu) begin
          if (is_div) begin
            if (b_zero) begin
              st_code <= ST_DIV_ZERO;
              mode    <= MODE_HALT;
            end
          end else if (op == OP_JAL) begin
            // a link into the pc is replaced by the target
            if (d != REG_PC) rf[d] <= rf[REG_PC];
            rf[REG_PC] <= b;
            ztw        <= (d == REG_PC) ? b : rf[REG_PC];
          end else if (op != OP_LOAD && op != OP_LOAD_FB) begin
            // stores keep rd and still set the zero-test word from it
            rf[d] <= alu_r;
            ztw   <= alu_r;
          end
        end else if (is_svc) begin
          if (svc_n == SVC_HALT) begin
            st_code <= ST_HALTED;
            mode    <= MODE_HALT;
          end else if (svc_n > SVC_LAST) begin
            st_code <= ST_UNKNOWN;
            mode    <= MODE_HALT;
          end else begin
            st_code <= ST_SERVICE;
            svc_q   <= svc_n[3:0];
            if (svc_n == SVC_PUTC || svc_n == SVC_DEBUG) begin
              ztw <= rf[REG_ARG1];
            end else begin
              rep_q <= 1'b1;
              mode  <= MODE_WAIT;
            end
          end
        end else if (take) begin
          rf[REG_PC] <= rf[REG_PC] + br_off;
        end
      end
      if (cmd.memrd) begin
        rf[d] <= ram_rd;
        ztw   <= ram_rd;
      end
      if (cmd.div_wait && div_done) begin
        rf[d] <= (op == OP_DIV_S || op == OP_DIV_U) ? div_quo : div_rem;
        ztw   <= (op == OP_DIV_S || op == OP_DIV_U) ? div_quo : div_rem;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status          <= st_code;
      program_counter <= rf[REG_PC];
      service_number  <= svc_q;
      needs_reply     <= rep_q;
      arg_first       <= (st_code == ST_SERVICE) ? rf[REG_ARG1] : 16'd0;
      arg_second      <= (st_code == ST_SERVICE) ? rf[REG_ARG2] : 16'd0;
    end
  end
endmodule
`default_nettype wire
